[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue_top.
package spq_pkg;

    localparam int DATA_W    = 32;
    localparam int PRIO_W    = 8;
    localparam int OCC_W     = 4;
    localparam int DEPTH_DEF = 8;

    typedef enum logic {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_ENQ = 2'd0,
        ST_DEQ = 2'd1,
        ST_OVF = 2'd2,
        ST_UNF = 2'd3
    } status_t;

    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } cell_op_t;

endpackage

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds a data word and its priority.
// Depends on spq_pkg for field widths and the broadcast operation struct.
module spq_cell
    import spq_pkg::*;
(
    input  logic              clk,
    input  cell_op_t          op,
    input  logic              occ,
    input  logic              gt_left,
    input  logic [DATA_W-1:0] left_data,
    input  logic [PRIO_W-1:0] left_prio,
    input  logic [DATA_W-1:0] right_data,
    input  logic [PRIO_W-1:0] right_prio,
    output logic              gt,
    output logic [DATA_W-1:0] data,
    output logic [PRIO_W-1:0] prio
);

    logic [DATA_W-1:0] data_reg;
    logic [PRIO_W-1:0] prio_reg;

    // empty slots rank after every held entry
    assign gt   = !occ || (prio_reg > op.prio);
    assign data = data_reg;
    assign prio = prio_reg;

    always_ff @(posedge clk)
    begin
        if (op.enq)
        begin
            if (gt_left)
            begin
                data_reg <= left_data;
                prio_reg <= left_prio;
            end
            else if (gt)
            begin
                data_reg <= op.data;
                prio_reg <= op.prio;
            end
        end
        else if (op.deq)
        begin
            data_reg <= right_data;
            prio_reg <= right_prio;
        end
    end

endmodule

[rtl/sorted_priority_queue_top.sv]
// Sorted priority queue: a row of DEPTH cells kept in ascending priority order.
// Results are registered and appear in the cycle after their input is accepted.
// One word per cycle unless m_tready stalls; all cells compare and shift together.
// Reset: rst_n clears the entry count and the output valid; slot contents are
// left as they are and are never read before being written.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_data[31:0], item_priority[39:32]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_data[31:0], occupancy[35:32], zero[39:36]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    status_t           out_status_reg, out_status_next;
    logic [OCC_W-1:0]  out_occ_reg, occ_next;

    logic              s_acc;
    mode_t             mode;
    logic              full, empty, enq_ok, deq_ok;
    cell_op_t          op;

    logic [DEPTH-1:0]  gt;
    logic [DEPTH-1:0]  occ;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [PRIO_W-1:0] cell_prio [DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser[0]);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign enq_ok   = s_acc && (mode == MODE_ENQ) && !full;
    assign deq_ok   = s_acc && (mode == MODE_DEQ) && !empty;

    assign op = '{enq: enq_ok, deq: deq_ok, prio: s_tdata[39:32], data: s_tdata[31:0]};

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic              gt_l;
            logic [DATA_W-1:0] ld, rd;
            logic [PRIO_W-1:0] lp, rp;

            assign occ[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign gt_l = 1'b0;
                assign ld   = op.data;
                assign lp   = op.prio;
            end
            else
            begin : g_mid
                assign gt_l = gt[i-1];
                assign ld   = cell_data[i-1];
                assign lp   = cell_prio[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign rd = '0;
                assign rp = '0;
            end
            else
            begin : g_body
                assign rd = cell_data[i+1];
                assign rp = cell_prio[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .op         (op),
                .occ        (occ[i]),
                .gt_left    (gt_l),
                .left_data  (ld),
                .left_prio  (lp),
                .right_data (rd),
                .right_prio (rp),
                .gt         (gt[i]),
                .data       (cell_data[i]),
                .prio       (cell_prio[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (deq_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    generate
        if (CNT_W >= OCC_W)
        begin : g_occ_trunc
            assign occ_next = count_next[OCC_W-1:0];
        end
        else
        begin : g_occ_ext
            assign occ_next = {{(OCC_W - CNT_W){1'b0}}, count_next};
        end
    endgenerate

    always_comb
    begin
        out_data_next = '0;
        case (mode)
            MODE_ENQ:
            begin
                out_status_next = full ? ST_OVF : ST_ENQ;
            end
            MODE_DEQ:
            begin
                out_status_next = empty ? ST_UNF : ST_DEQ;
                if (!empty)
                begin
                    out_data_next = cell_data[0];
                end
            end
            default:
            begin
                out_status_next = ST_UNF;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= occ_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_occ_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (mode == MODE_ENQ) && full) |=>
            ((m_tuser == ST_OVF) && (count_reg == CNT_W'(DEPTH))))
        else $error("full enqueue not rejected");

    a_unf: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (mode == MODE_DEQ) && empty) |=>
            ((m_tuser == ST_UNF) && (m_tdata[31:0] == '0) && (count_reg == '0)))
        else $error("empty dequeue not flagged");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_ok |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not advance count");

endmodule

[test/sorted_priority_queue_top_tb.sv]
// Self-checking testbench for sorted_priority_queue_top: a directed table, then random
// enqueue/dequeue phases with idle bursts, checked against a sorted-queue predictor.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
`timescale 1ns / 100ps

module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int DIR_ROWS    = 24;
    localparam int RAND_WORDS  = 1630;
    localparam int QUIET_WORDS = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        status_t           status;
        logic [OCC_W-1:0]  occ;
    } result_t;

    typedef struct packed {
        mode_t             mode;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
        logic              typed;
        result_t           want;
    } dir_row_t;

    localparam result_t UNTYPED = '{data: 32'h0, status: ST_ENQ, occ: 4'd0};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = 40'h0;   // item_data[31:0], item_priority[39:32]
    logic [0:0]  s_tuser  = 1'b0;    // mode[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // out_data[31:0], occupancy[35:32], zero[39:36]
    logic [1:0]  m_tuser;            // status[1:0]

    // predictor state
    logic [DATA_W-1:0] pq_data [QDEPTH];
    logic [PRIO_W-1:0] pq_prio [QDEPTH];
    int                pq_count = 0;

    result_t result_q[$];
    logic    cur_typed = 1'b0;
    result_t cur_want  = UNTYPED;

    int     err_cnt     = 0;
    int     cycle_cnt   = 0;
    int     word_cnt    = 0;
    int     enq_cnt     = 0;
    int     deq_cnt     = 0;
    int     ovf_cnt     = 0;
    int     unf_cnt     = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    logic   hold_req    = 1'b0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b1, '{32'h0000_0000, ST_UNF, 4'd0}},
        '{MODE_ENQ, 32'h7FFF_FFFF, 8'd255, 1'b1, '{32'h0000_0000, ST_ENQ, 4'd1}},
        '{MODE_ENQ, 32'h8000_0000, 8'd0,   1'b1, '{32'h0000_0000, ST_ENQ, 4'd2}},
        '{MODE_DEQ, 32'hFFFF_FFFF, 8'd255, 1'b1, '{32'h8000_0000, ST_DEQ, 4'd1}},
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b1, '{32'h7FFF_FFFF, ST_DEQ, 4'd0}},
        '{MODE_DEQ, 32'h1234_5678, 8'd17,  1'b1, '{32'h0000_0000, ST_UNF, 4'd0}},
        '{MODE_ENQ, 32'h0000_0001, 8'd5,   1'b1, '{32'h0000_0000, ST_ENQ, 4'd1}},
        '{MODE_ENQ, 32'h0000_0002, 8'd5,   1'b1, '{32'h0000_0000, ST_ENQ, 4'd2}},
        '{MODE_ENQ, 32'h0000_0003, 8'd3,   1'b1, '{32'h0000_0000, ST_ENQ, 4'd3}},
        '{MODE_ENQ, 32'hFFFF_FFFF, 8'd255, 1'b1, '{32'h0000_0000, ST_ENQ, 4'd4}},
        '{MODE_ENQ, 32'h0000_0000, 8'd0,   1'b1, '{32'h0000_0000, ST_ENQ, 4'd5}},
        '{MODE_ENQ, 32'h0000_0004, 8'd5,   1'b1, '{32'h0000_0000, ST_ENQ, 4'd6}},
        '{MODE_ENQ, 32'hA5A5_5A5A, 8'd7,   1'b1, '{32'h0000_0000, ST_ENQ, 4'd7}},
        '{MODE_ENQ, 32'h0000_0006, 8'd5,   1'b1, '{32'h0000_0000, ST_ENQ, 4'd8}},
        '{MODE_ENQ, 32'h8000_0000, 8'd0,   1'b1, '{32'h0000_0000, ST_OVF, 4'd8}},
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b0, UNTYPED},
        '{MODE_DEQ, 32'hFFFF_FFFF, 8'd255, 1'b0, UNTYPED},
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b0, UNTYPED},
        '{MODE_DEQ, 32'h5555_AAAA, 8'd128, 1'b0, UNTYPED},
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b0, UNTYPED},
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b0, UNTYPED},
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b0, UNTYPED},
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b0, UNTYPED},
        '{MODE_DEQ, 32'h0000_0000, 8'd0,   1'b1, '{32'h0000_0000, ST_UNF, 4'd0}}
    };

    sorted_priority_queue_top #(
        .DEPTH (QDEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // insert after equal or smaller priorities, remove from the head
    function automatic result_t queue_apply(mode_t mode, logic [DATA_W-1:0] data,
                                            logic [PRIO_W-1:0] prio);
        result_t r;
        int      pos;
        r = '{data: '0, status: ST_ENQ, occ: '0};
        if (mode == MODE_ENQ) begin
            if (pq_count >= QDEPTH) begin
                r.status = ST_OVF;
            end
            else begin
                pos = 0;
                while (pos < pq_count && pq_prio[pos] <= prio)
                    pos++;
                for (int i = pq_count; i > pos; i--)
                begin
                    pq_data[i] = pq_data[i-1];
                    pq_prio[i] = pq_prio[i-1];
                end
                pq_data[pos] = data;
                pq_prio[pos] = prio;
                pq_count++;
            end
        end
        else if (pq_count == 0) begin
            r.status = ST_UNF;
        end
        else begin
            r.data = pq_data[0];
            for (int i = 1; i < pq_count; i++)
            begin
                pq_data[i-1] = pq_data[i];
                pq_prio[i-1] = pq_prio[i];
            end
            pq_count--;
            r.status = ST_DEQ;
        end
        r.occ = pq_count[OCC_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t pred;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("FAIL");
            $finish;
        end
        else if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result word data=%h status=%0d occ=%0d",
                             $time, m_tdata[31:0], m_tuser, m_tdata[35:32]);
                end
                else begin
                    want = result_q.pop_front();
                    if (m_tdata[31:0] !== want.data) begin
                        err_cnt++;
                        $display("%0t: out_data expected %h actual %h",
                                 $time, want.data, m_tdata[31:0]);
                    end
                    if (m_tuser !== want.status) begin
                        err_cnt++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                    end
                    if (m_tdata[35:32] !== want.occ) begin
                        err_cnt++;
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occ, m_tdata[35:32]);
                    end
                    if (m_tdata[39:36] !== 4'd0) begin
                        err_cnt++;
                        $display("%0t: pad bits expected 0 actual %h",
                                 $time, m_tdata[39:36]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pred = queue_apply(mode_t'(s_tuser[0]), s_tdata[31:0], s_tdata[39:32]);
                word_cnt++;
                case (pred.status)
                    ST_ENQ:  enq_cnt++;
                    ST_DEQ:  deq_cnt++;
                    ST_OVF:  ovf_cnt++;
                    default: unf_cnt++;
                endcase
                result_q.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_req = 1'b0;
                m_tready = 1'b1;
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                m_tready = 1'b1;
            end
            else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_word(input mode_t mode, input logic [DATA_W-1:0] data,
                             input logic [PRIO_W-1:0] prio, input logic typed,
                             input result_t want);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid  = 1'b1;
        s_tuser   = mode;
        s_tdata   = {prio, data};
        cur_typed = typed;
        cur_want  = want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 40;
        endcase
    endfunction

    initial
    begin : stimulus
        int                n;
        int                kind;
        int                left;
        int                enq_pct;
        mode_t             mode;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
        kind = 0;
        left = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        for (n = 0; n < DIR_ROWS; n++)
            send_word(dir_rows[n].mode, dir_rows[n].data, dir_rows[n].prio,
                      dir_rows[n].typed, dir_rows[n].want);
        wait_drained();

        // kinds: 0 fill, 1 drain, 2 balanced, 3 tight priority range
        for (n = 0; n < RAND_WORDS; n++) begin
            if (n >= RAND_WORDS - QUIET_WORDS) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                if (left <= 0) begin
                    kind = $urandom_range(0, 3);
                    left = $urandom_range(8, 40);
                end
            end
            else if (n == 200) begin
                // hold the receiver off while words keep coming
                wait_drained();
                tx_idle_pct = 0;
                hold_req    = 1'b1;
                kind        = 0;
                left        = 30;
            end
            else if (n % 400 == 399) begin
                wait_drained();
            end
            else if (left <= 0) begin
                kind        = $urandom_range(0, 3);
                left        = $urandom_range(8, 40);
                tx_idle_pct = pick_idle_pct();
                rx_idle_pct = pick_idle_pct();
            end
            left--;

            case (kind)
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                2:       enq_pct = 50;
                default: enq_pct = 60;
            endcase
            mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;

            if (kind == 3)
                prio = $urandom_range(0, 3);
            else begin
                case ($urandom_range(0, 7))
                    0:       prio = 8'd0;
                    1:       prio = 8'd255;
                    default: prio = $urandom_range(0, 255);
                endcase
            end

            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 3))
                    0:       data = 32'h8000_0000;
                    1:       data = 32'h7FFF_FFFF;
                    2:       data = 32'hFFFF_FFFF;
                    default: data = 32'h0000_0000;
                endcase
            end
            else begin
                data = $urandom;
            end

            send_word(mode, data, prio, 1'b0, UNTYPED);
        end

        wait_drained();
        repeat (10) @(negedge clk);
        $display("Ran %0d words: %0d enqueued, %0d dequeued, %0d overflows, %0d underflows,",
                 word_cnt, enq_cnt, deq_cnt, ovf_cnt, unf_cnt);
        $display("with idle bursts, a %0d-cycle receiver hold-off and drain pauses.",
                 HOLD_CYCLES);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
